// File: hw/rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// shared types and constants for the binary to decimal ascii converter
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_NONE  = 8'h00;

   typedef struct packed {
      logic [63:0] value;
      logic        is_signed;
      logic [7:0]  room;
   } b2da_req_type;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
      logic       overflow;
   } b2da_rsp_type;

   // control from the sequencer to the bcd shift register
   typedef struct packed {
      logic clear;
      logic shift;
      logic bit_in;
   } b2da_dab_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_CHECK,
      ST_EMIT
   } b2da_state_type;

endpackage

// File: hw/rtl/b2da_dabble.sv
// ----------------------------------------------------------------------------
// b2da_dabble
// bit-serial double dabble bcd register with significant digit count
// ----------------------------------------------------------------------------
module b2da_dabble
   import b2da_pkg::*;
#(
   parameter int NUM_DIGITS = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  b2da_dab_ctl_type            ctl,
   output logic [NUM_DIGITS-1:0][3:0]  digits,
   output logic [$clog2(NUM_DIGITS+1)-1:0] num_sig
);

   localparam int NdW  = $clog2(NUM_DIGITS + 1);
   localparam int IdxW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   logic [NUM_DIGITS-1:0][3:0] digits_ff, digits_in;
   logic [NUM_DIGITS-1:0][3:0] adjusted;
   logic [NdW-1:0]             nd_ff, nd_in;
   logic [IdxW-1:0]            sel;

   // add 3 to every digit of 5 or more, then shift the whole register left
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adjusted[i] = (digits_ff[i] >= 4'd5) ? digits_ff[i] + 4'd3 : digits_ff[i];
      end
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (i == 0) begin
            digits_in[i] = {adjusted[i][2:0], ctl.bit_in};
         end else begin
            digits_in[i] = {adjusted[i][2:0], adjusted[i-1][3]};
         end
      end
   end

   // the value at most doubles per shift, so the count grows by at most one
   always_comb begin
      sel   = (nd_ff < NdW'(NUM_DIGITS)) ? nd_ff[IdxW-1:0] : '0;
      nd_in = nd_ff;
      if (nd_ff < NdW'(NUM_DIGITS) && digits_in[sel] != 4'd0) begin
         nd_in = nd_ff + NdW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nd_ff <= NdW'(1);
      end else if (ctl.clear) begin
         nd_ff <= NdW'(1);
      end else if (ctl.shift) begin
         nd_ff <= nd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         digits_ff <= '0;
      end else if (ctl.shift) begin
         digits_ff <= digits_in;
      end
   end

   assign digits  = digits_ff;
   assign num_sig = nd_ff;

endmodule

// File: hw/rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// converts a binary value to its decimal ascii text, one character per cycle
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The low VALUE_WIDTH
// bits of value are converted; with is_signed set and the top bit set, a '-'
// precedes the magnitude. Characters leave most significant digit first, one
// per cycle, each flagged by rsp_strobe for a single cycle; the receiver
// cannot stall, so it must take every strobed character. If room is below the
// character count plus one terminator byte, a single result with character 0,
// last and overflow set is sent instead of the text. A bit-serial double dabble
// shifts in the magnitude one bit per cycle, then the room is checked, then the
// results are sent; busy drops in the same cycle that the last result is on
// the ports, so the next request may be taken in that cycle.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii
   import b2da_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  b2da_req_type req_data,
   output logic         rsp_strobe,
   output b2da_rsp_type rsp_data
);

   // digits of 2^W - 1 is floor(W * log10(2)) + 1
   localparam int NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int NdW       = $clog2(NumDigits + 1);
   localparam int IdxW      = (NumDigits > 1) ? $clog2(NumDigits) : 1;
   localparam int CntW      = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   b2da_state_type state_ff, state_in;

   // request context
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [7:0]             room_ff, room_in;
   logic [CntW-1:0]        cnt_ff, cnt_in;

   // emission context
   logic                   ovf_ff, ovf_in;
   logic                   minus_ff, minus_in;
   logic [IdxW-1:0]        idx_ff, idx_in;

   // registered result port
   logic                   strobe_ff, strobe_in;
   b2da_rsp_type           rsp_ff, rsp_in;

   b2da_dab_ctl_type           dab_ctl;
   logic [NumDigits-1:0][3:0]  digits;
   logic [NdW-1:0]             num_sig;

   logic [VALUE_WIDTH-1:0] raw;
   logic                   raw_neg;
   logic [7:0]             need;
   logic [NdW-1:0]         top_idx;

   assign raw     = req_data.value[VALUE_WIDTH-1:0];
   assign raw_neg = req_data.is_signed & raw[VALUE_WIDTH-1];
   // characters plus terminator
   assign need    = 8'(num_sig) + 8'(neg_ff) + 8'd1;
   assign top_idx = num_sig - NdW'(1);

   b2da_dabble #(
      .NUM_DIGITS (NumDigits)
   ) u_dabble (
      .clock   (clock),
      .reset   (reset),
      .ctl     (dab_ctl),
      .digits  (digits),
      .num_sig (num_sig)
   );

   // sequencer
   always_comb begin
      state_in  = state_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      room_in   = room_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      minus_in  = minus_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      dab_ctl   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               // negate once at load, magnitude then shifts out msb first
               mag_in        = raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;
               neg_in        = raw_neg;
               room_in       = req_data.room;
               cnt_in        = CntW'(VALUE_WIDTH - 1);
               dab_ctl.clear = 1'b1;
               state_in      = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            dab_ctl.shift  = 1'b1;
            dab_ctl.bit_in = mag_ff[VALUE_WIDTH-1];
            mag_in         = mag_ff << 1;
            if (cnt_ff == '0) begin
               state_in = ST_CHECK;
            end else begin
               cnt_in = cnt_ff - CntW'(1);
            end
         end
         ST_CHECK: begin
            ovf_in   = room_ff < need;
            minus_in = neg_ff;
            idx_in   = top_idx[IdxW-1:0];
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            strobe_in = 1'b1;
            if (ovf_ff) begin
               // room too small: lone error result
               rsp_in.character = CHAR_NONE;
               rsp_in.last      = 1'b1;
               rsp_in.overflow  = 1'b1;
               state_in         = ST_IDLE;
            end else if (minus_ff) begin
               rsp_in.character = CHAR_MINUS;
               rsp_in.last      = 1'b0;
               rsp_in.overflow  = 1'b0;
               minus_in         = 1'b0;
            end else begin
               rsp_in.character = CHAR_ZERO | {4'h0, digits[idx_ff]};
               rsp_in.last      = (idx_ff == '0);
               rsp_in.overflow  = 1'b0;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IdxW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload and context
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      room_ff  <= room_in;
      cnt_ff   <= cnt_in;
      ovf_ff   <= ovf_in;
      minus_ff <= minus_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: hw/rtl/b2da_checker.sv
// ----------------------------------------------------------------------------
// b2da_checker
// port-level assertions for the binary to decimal ascii converter
// ----------------------------------------------------------------------------
module b2da_checker
   import b2da_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_strobe,
   input b2da_rsp_type rsp_data
);

   // an accepted request keeps the block busy next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // every result belongs to a request in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result without request in progress");

   // error result is a lone final result with a null character
   a_ovf_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.overflow) |-> (rsp_data.last && rsp_data.character == CHAR_NONE))
      else $error("malformed overflow result");

   // text characters are a minus or a decimal digit, and minus never ends text
   a_char_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.overflow) |->
         ((rsp_data.character == CHAR_MINUS && !rsp_data.last) ||
          (rsp_data.character >= CHAR_ZERO && rsp_data.character <= (CHAR_ZERO + 8'd9))))
      else $error("bad text character");

   // a new request needs conversion time, so no result right after the last
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.last) |=> !rsp_strobe)
      else $error("result directly after last");

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);
